// ===== src/assert_macros.svh =====
// assert_macros.svh: assertion macros used by the checker file
// expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define MGH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// clocked check that also holds during reset
`define MGH_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mgh_pkg.sv =====
// mgh_pkg: types, constants and the arctangent table of the heading core
// no dependencies; imported by every mgh module and the top level
package mgh_pkg;

	localparam int BYTE_W     = 8;
	localparam int AXIS_W     = 16;
	localparam int HEAD_W     = 15;
	localparam int AXIS_SCALE = 16;
	localparam int ANG_FRAC   = 24;
	localparam int TABLE_LEN  = 24;
	localparam int CW         = AXIS_W + AXIS_SCALE + 3;
	localparam int ZW         = 32;
	localparam int ANG_W      = 34;

	typedef logic [1:0] sensor_type_t;
	localparam sensor_type_t ST_NONE   = 2'd0;
	localparam sensor_type_t ST_BIG_A  = 2'd1;
	localparam sensor_type_t ST_BIG_B  = 2'd2;
	localparam sensor_type_t ST_LITTLE = 2'd3;

	typedef logic [2:0] base_t;
	localparam base_t BASE_0   = 3'd0;
	localparam base_t BASE_90  = 3'd1;
	localparam base_t BASE_180 = 3'd2;
	localparam base_t BASE_270 = 3'd3;
	localparam base_t BASE_360 = 3'd4;

	localparam logic signed [ANG_W-1:0] ANG_360 = ANG_W'(360) << ANG_FRAC;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_0;
		logic [BYTE_W-1:0] byte_1;
		logic [BYTE_W-1:0] byte_2;
		logic [BYTE_W-1:0] byte_3;
		logic [BYTE_W-1:0] byte_4;
		logic [BYTE_W-1:0] byte_5;
	} mgh_in_t;

	typedef struct packed {
		logic [HEAD_W-1:0]        heading;
		logic signed [AXIS_W-1:0] axis_x;
		logic signed [AXIS_W-1:0] axis_y;
		logic signed [AXIS_W-1:0] axis_z;
	} mgh_out_t;

	typedef struct packed {
		logic                     pinned;
		base_t                    base;
		logic signed [CW-1:0]     cx;
		logic signed [CW-1:0]     cy;
		logic signed [ZW-1:0]     ang;
		logic signed [AXIS_W-1:0] ax;
		logic signed [AXIS_W-1:0] ay;
		logic signed [AXIS_W-1:0] az;
	} mgh_stage_t;

	typedef struct packed {
		logic [ANG_W-2:0]         ang;
		logic signed [AXIS_W-1:0] ax;
		logic signed [AXIS_W-1:0] ay;
		logic signed [AXIS_W-1:0] az;
	} mgh_fin_t;

	// atan(2^-i) in degrees, 2^-24 degree units
	localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
		32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
		32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
		32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
		32'sd234683,    32'sd117342,    32'sd58671,     32'sd29335,
		32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
		32'sd917,       32'sd458,       32'sd229,       32'sd115
	};

	function automatic logic signed [ANG_W-1:0] base_angle(base_t code);
		logic signed [ANG_W-1:0] a;
		case (code)
			BASE_90:  a = ANG_W'(90) << ANG_FRAC;
			BASE_180: a = ANG_W'(180) << ANG_FRAC;
			BASE_270: a = ANG_W'(270) << ANG_FRAC;
			BASE_360: a = ANG_360;
			default:  a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== src/mgh_unpack.sv =====
// mgh_unpack: first pipeline stage, byte assembly, special cases and half-plane turn
// depends on mgh_pkg
module mgh_unpack
	import mgh_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_valid,
	input  mgh_in_t      in_data,
	input  sensor_type_t sensor_type,
	output logic         out_valid,
	output mgh_stage_t   out_data
);

	logic signed [AXIS_W-1:0] ax, ay, az;
	logic signed [CW-1:0]     xs, ys;
	logic                     none, x_zero, y_zero;
	mgh_stage_t               nxt;
	logic                     valid_s1;
	mgh_stage_t               data_s1;

	always_comb begin
		ax   = '0;
		ay   = '0;
		az   = '0;
		none = 1'b0;
		unique case (sensor_type) inside
			ST_BIG_A, ST_BIG_B: begin
				ax = {in_data.byte_0, in_data.byte_1};
				az = {in_data.byte_2, in_data.byte_3};
				ay = {in_data.byte_4, in_data.byte_5};
			end
			ST_LITTLE: begin
				ax = {in_data.byte_1, in_data.byte_0};
				ay = {in_data.byte_3, in_data.byte_2};
				az = {in_data.byte_5, in_data.byte_4};
			end
			ST_NONE: begin
				none = 1'b1;
			end
		endcase
	end

	assign x_zero = (ax == '0);
	assign y_zero = (ay == '0);
	assign xs = {{(CW-AXIS_W-AXIS_SCALE){ax[AXIS_W-1]}}, ax, {AXIS_SCALE{1'b0}}};
	assign ys = {{(CW-AXIS_W-AXIS_SCALE){ay[AXIS_W-1]}}, ay, {AXIS_SCALE{1'b0}}};

	always_comb begin
		nxt.pinned = none | x_zero | y_zero;
		if (none) begin
			nxt.base = BASE_0;
		end else if (x_zero && y_zero) begin
			nxt.base = BASE_180;
		end else if (y_zero) begin
			nxt.base = ax[AXIS_W-1] ? BASE_360 : BASE_180;
		end else if (x_zero) begin
			nxt.base = ay[AXIS_W-1] ? BASE_90 : BASE_270;
		end else if (ax[AXIS_W-1]) begin
			nxt.base = ay[AXIS_W-1] ? BASE_0 : BASE_360;
		end else begin
			nxt.base = BASE_180;
		end
		// left half plane turned by 180 degrees
		nxt.cx  = ax[AXIS_W-1] ? -xs : xs;
		nxt.cy  = ax[AXIS_W-1] ? -ys : ys;
		nxt.ang = '0;
		nxt.ax  = ax;
		nxt.ay  = ay;
		nxt.az  = az;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ===== src/mgh_cordic_stage.sv =====
// mgh_cordic_stage: one registered vectoring-mode cordic iteration
// depends on mgh_pkg for the stage type and the arctangent table
module mgh_cordic_stage
	import mgh_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_valid,
	input  mgh_stage_t in_data,
	output logic       out_valid,
	output mgh_stage_t out_data
);

	logic signed [CW-1:0] dx, dy;
	mgh_stage_t           nxt;
	logic                 valid_s1;
	mgh_stage_t           data_s1;

	assign dx = in_data.cy >>> IDX;
	assign dy = in_data.cx >>> IDX;

	always_comb begin
		nxt = in_data;
		if (!in_data.cy[CW-1]) begin
			nxt.cx  = in_data.cx + dx;
			nxt.cy  = in_data.cy - dy;
			nxt.ang = in_data.ang + ATAN_TAB[IDX];
		end else begin
			nxt.cx  = in_data.cx - dx;
			nxt.cy  = in_data.cy + dy;
			nxt.ang = in_data.ang - ATAN_TAB[IDX];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ===== src/mgh_finish.sv =====
// mgh_finish: adds the base angle, applies pinned cases and clamps to 0..360 degrees
// depends on mgh_pkg
module mgh_finish
	import mgh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_valid,
	input  mgh_stage_t in_data,
	output logic       out_valid,
	output mgh_fin_t   out_data
);

	logic signed [ANG_W-1:0] base, h;
	mgh_fin_t                nxt;
	logic                    valid_s1;
	mgh_fin_t                data_s1;

	assign base = base_angle(in_data.base);
	assign h    = in_data.pinned ? base
		: base + {{(ANG_W-ZW){in_data.ang[ZW-1]}}, in_data.ang};

	always_comb begin
		if (h[ANG_W-1]) begin
			nxt.ang = '0;
		end else if (h > ANG_360) begin
			nxt.ang = ANG_360[ANG_W-2:0];
		end else begin
			nxt.ang = h[ANG_W-2:0];
		end
		nxt.ax = in_data.ax;
		nxt.ay = in_data.ay;
		nxt.az = in_data.az;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ===== src/magnetometer_heading_core.sv =====
// magnetometer_heading_core: axis assembly and cordic compass heading, top level
// depends on mgh_pkg, mgh_unpack, mgh_cordic_stage and mgh_finish
//
//  channel  handshake            payload
//  in       in_valid/in_ready    in_data   (mgh_in_t, six raw register bytes)
//  out      out_valid/out_ready  out_data  (mgh_out_t, heading and axes)
//  cfg      cfg_we               cfg_wdata (sensor type, no read-back)
//
// one beat in and one out per cycle while the output is not held; the registers are
// unpack, one per cordic iteration, clamp and the rounding output register
// every stage has its own valid bit and loads when empty or when the next one moves,
// so bubbles close up behind a held output and the input stalls only once all are full
// reset clears the valid bits and the sensor type (undefined, heading 0)
module magnetometer_heading_core
	import mgh_pkg::*;
#(
	parameter int CORDIC_STAGES = 16,
	parameter int FRACTION_BITS = 6
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  sensor_type_t cfg_wdata,
	input  logic         in_valid,
	output logic         in_ready,
	input  mgh_in_t      in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output mgh_out_t     out_data
);

	localparam int NSTG  = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
	localparam int NREG  = NSTG + 2;
	localparam int SHIFT = ANG_FRAC - FRACTION_BITS;
	localparam int RND_W = ANG_FRAC + HEAD_W;

	sensor_type_t           sensor_type_q;
	logic [NREG:0]          en;
	logic [NREG-1:0]        v;
	mgh_stage_t             cd [NSTG+1];
	mgh_fin_t               fin;
	logic [RND_W-1:0]       rnd;
	logic                   out_valid_q;
	mgh_out_t               out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_type_q <= ST_NONE;
		end else if (cfg_we) begin
			sensor_type_q <= cfg_wdata;
		end
	end

	// stage enables, bubble collapsing back from the output register
	assign en[NREG] = !out_valid_q || out_ready;
	for (genvar k = 0; k < NREG; k++) begin : g_en
		assign en[k] = !v[k] || en[k+1];
	end
	assign in_ready = en[0];

	mgh_unpack u_unpack (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en[0]),
		.in_valid    (in_valid),
		.in_data     (in_data),
		.sensor_type (sensor_type_q),
		.out_valid   (v[0]),
		.out_data    (cd[0])
	);

	for (genvar i = 0; i < NSTG; i++) begin : g_cordic
		mgh_cordic_stage #(
			.IDX (i)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en[i+1]),
			.in_valid  (v[i]),
			.in_data   (cd[i]),
			.out_valid (v[i+1]),
			.out_data  (cd[i+1])
		);
	end

	mgh_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en[NSTG+1]),
		.in_valid  (v[NSTG]),
		.in_data   (cd[NSTG]),
		.out_valid (v[NSTG+1]),
		.out_data  (fin)
	);

	// round half up to the output fraction bits
	assign rnd = RND_W'(fin.ang) + (RND_W'(1) << (SHIFT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en[NREG]) begin
			out_valid_q <= v[NREG-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NREG] && v[NREG-1]) begin
			out_q.heading <= rnd[SHIFT +: HEAD_W];
			out_q.axis_x  <= fin.ax;
			out_q.axis_y  <= fin.ay;
			out_q.axis_z  <= fin.az;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== src/mgh_checker.sv =====
// mgh_checker: port-level checks on the heading core, bound to the top level
// depends on mgh_pkg and assert_macros.svh
`include "assert_macros.svh"

module mgh_checker
	import mgh_pkg::*;
#(
	parameter int FRACTION_BITS = 6
) (
	input logic     clk,
	input logic     arst_n,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input mgh_out_t out_data
);

	localparam logic [HEAD_W-1:0] H180 = HEAD_W'(180 << FRACTION_BITS);

	logic held, zero_vec, pos_x, zero_ok;

	assign held     = out_valid && !out_ready;
	assign zero_vec = (out_data.axis_x == '0) && (out_data.axis_y == '0);
	assign pos_x    = (out_data.axis_y == '0) && !out_data.axis_x[AXIS_W-1]
		&& (out_data.axis_x != '0);
	assign zero_ok  = (out_data.heading == H180) || (out_data.heading == '0);

	`MGH_ASSERT_RST(a_reset_empty, !arst_n |-> !out_valid, "output valid during reset")

	// held beat keeps its payload
	`MGH_ASSERT(a_out_hold, held |=> out_valid && $stable(out_data), "held beat changed")

	// input stalls only behind a held output
	`MGH_ASSERT(a_stall_cause, !in_ready |-> held, "input stalled without back-pressure")

	`MGH_ASSERT(a_zero_vec, out_valid && zero_vec |-> zero_ok, "zero vector heading wrong")

	`MGH_ASSERT(a_pos_x_axis, out_valid && pos_x |-> out_data.heading == H180, "x axis heading wrong")

endmodule

bind magnetometer_heading_core mgh_checker #(
	.FRACTION_BITS (FRACTION_BITS)
) u_mgh_checker (.*);

// ===== dv/magnetometer_heading_core_tb.sv =====
// magnetometer_heading_core_tb: self-checking bench for the compass heading core
// needs mgh_pkg and the core; predicts axis assembly and cordic heading per beat
// and checks every output beat in order under random idling and back-pressure
module magnetometer_heading_core_tb;
	import mgh_pkg::*;

	localparam int STAGES      = 16;
	localparam int FRAC        = 6;
	localparam int LAT         = STAGES + 3;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int REPORT_MAX  = 100;

	// atan(2^-i) in units of 2^-24 degree
	localparam longint ATAN_FINE [24] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367,
		234683, 117342, 58671, 29335, 14668, 7334,
		3667, 1833, 917, 458, 229, 115
	};

	logic         clk = 1'b0;
	logic         arst_n;
	logic         cfg_we = 1'b0;
	sensor_type_t cfg_wdata = ST_NONE;
	logic         in_valid = 1'b0;
	logic         in_ready;
	mgh_in_t      in_data = '0;
	logic         out_valid;
	logic         out_ready = 1'b0;
	mgh_out_t     out_data;

	sensor_type_t sensor_now = ST_NONE;
	mgh_out_t     heading_due [$];
	int           mismatches = 0;
	int           src_idle = 0;
	int           snk_stall = 0;
	int           hold_req = 0;
	int           hold_seen = 0;
	int           hold_left = 0;
	int           quiet_cycles = 0;

	magnetometer_heading_core #(
		.CORDIC_STAGES(STAGES),
		.FRACTION_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #6 clk = ~clk;

	function automatic mgh_out_t predict_heading(mgh_in_t d, sensor_type_t st);
		logic signed [15:0] ax, ay, az;
		longint deg, cx, cy, t, ang, h, dx, dy;
		longint unsigned hd;
		mgh_out_t r;
		deg = longint'(1) << 24;
		r = '0;
		if (st == ST_NONE) begin
			return r;
		end
		if (st == ST_LITTLE) begin
			ax = {d.byte_1, d.byte_0};
			ay = {d.byte_3, d.byte_2};
			az = {d.byte_5, d.byte_4};
		end else begin
			ax = {d.byte_0, d.byte_1};
			az = {d.byte_2, d.byte_3};
			ay = {d.byte_4, d.byte_5};
		end
		if (ax == 0 && ay == 0) begin
			h = 180 * deg;
		end else if (ay == 0) begin
			h = (ax > 0) ? 180 * deg : 360 * deg;
		end else if (ax == 0) begin
			h = (ay > 0) ? 270 * deg : 90 * deg;
		end else begin
			cx = longint'(ax) * 65536;
			cy = longint'(ay) * 65536;
			// left half plane: turn by 180 degrees first
			if (ax < 0) begin
				h = (ay > 0) ? 360 * deg : 0;
				cx = -cx;
				cy = -cy;
			end else begin
				h = 180 * deg;
			end
			ang = 0;
			for (int i = 0; i < STAGES && i < 24; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cy >= 0) begin
					t = cx + dx;
					cy = cy - dy;
					ang += ATAN_FINE[i];
				end else begin
					t = cx - dx;
					cy = cy + dy;
					ang -= ATAN_FINE[i];
				end
				cx = t;
			end
			h += ang;
			if (h < 0) h = 0;
			if (h > 360 * deg) h = 360 * deg;
		end
		hd = (h + (longint'(1) << (23 - FRAC))) >> (24 - FRAC);
		r.heading = hd[HEAD_W-1:0];
		r.axis_x = ax;
		r.axis_y = ay;
		r.axis_z = az;
		return r;
	endfunction

	function automatic mgh_in_t pack_axes(sensor_type_t st, logic [15:0] x, y, z);
		if (st == ST_LITTLE) begin
			return {x[7:0], x[15:8], y[7:0], y[15:8], z[7:0], z[15:8]};
		end
		return {x, z, y};
	endfunction

	function automatic logic [15:0] pick_axis(int mode);
		int v;
		case (mode)
			1: begin
				v = $urandom_range(0, 8);
				v = v - 4;
				return 16'(v);
			end
			2: begin
				case ($urandom_range(0, 4))
					0: return 16'h8000;
					1: return 16'hFFFF;
					2: return 16'h0000;
					3: return 16'h0001;
					default: return 16'h7FFF;
				endcase
			end
			3: return 16'h0000;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic mgh_in_t random_item(sensor_type_t st);
		logic [15:0] x, y;
		case ($urandom_range(0, 9))
			0: begin
				// one axis on zero, the other anything
				x = pick_axis($urandom_range(0, 3));
				y = pick_axis($urandom_range(0, 3));
				if ($urandom_range(0, 1)) x = '0;
				else y = '0;
				return pack_axes(st, x, y, pick_axis(0));
			end
			1: return pack_axes(st, pick_axis(1), pick_axis(1), pick_axis(1));
			2: return pack_axes(st, pick_axis(2), pick_axis(2), pick_axis(2));
			default: return mgh_in_t'({$urandom(), 16'($urandom())});
		endcase
	endfunction

	// entered and left at a falling edge
	task automatic send_beat(input mgh_in_t d);
		while ($urandom_range(0, 99) < src_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		do @(posedge clk); while (!in_ready);
		heading_due.push_back(predict_heading(d, sensor_now));
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (heading_due.size() != 0) @(negedge clk);
		repeat (LAT + 4) @(negedge clk);
	endtask

	task automatic write_sensor(sensor_type_t st);
		cfg_we <= 1'b1;
		cfg_wdata <= st;
		@(negedge clk);
		cfg_we <= 1'b0;
		sensor_now = st;
	endtask

	task automatic test_undefined_type();
		// reset value of the sensor type: heading and axes all zero
		send_beat({6{8'hFF}});
		send_beat('0);
		send_beat(random_item(ST_NONE));
		settle();
	endtask

	task automatic test_special_headings();
		write_sensor(ST_LITTLE);
		send_beat(pack_axes(ST_LITTLE, 16'h0000, 16'h0000, 16'h0000));
		send_beat(pack_axes(ST_LITTLE, 16'd100, 16'h0000, 16'h0005));
		send_beat(pack_axes(ST_LITTLE, -16'sd100, 16'h0000, 16'h0000));
		send_beat(pack_axes(ST_LITTLE, 16'h0000, 16'd100, 16'h0000));
		send_beat(pack_axes(ST_LITTLE, 16'h0000, -16'sd100, 16'h0000));
		send_beat(pack_axes(ST_LITTLE, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		send_beat(pack_axes(ST_LITTLE, 16'h8000, 16'h8000, 16'h8000));
		send_beat(pack_axes(ST_LITTLE, 16'h8000, 16'h7FFF, 16'h0000));
		send_beat(pack_axes(ST_LITTLE, 16'h7FFF, 16'h8000, 16'hFFFF));
		send_beat(pack_axes(ST_LITTLE, 16'h0001, 16'hFFFF, 16'h0000));
		send_beat(pack_axes(ST_LITTLE, 16'hFFFF, 16'h0001, 16'h0000));
		send_beat(pack_axes(ST_LITTLE, 16'h8000, 16'h0000, 16'h0001));
		settle();
		write_sensor(ST_BIG_A);
		send_beat(pack_axes(ST_BIG_A, 16'h7FFF, 16'h0001, 16'h8000));
		send_beat(pack_axes(ST_BIG_A, 16'hFFFF, 16'hFFFF, 16'h1234));
		send_beat(pack_axes(ST_BIG_A, 16'h0003, 16'h0004, 16'h0005));
		settle();
		write_sensor(ST_BIG_B);
		send_beat(pack_axes(ST_BIG_B, 16'h8000, 16'hFFFF, 16'h7FFF));
		send_beat(pack_axes(ST_BIG_B, 16'h0001, 16'h0001, 16'h0000));
		send_beat(pack_axes(ST_BIG_B, 16'hFFFF, 16'h8000, 16'hAAAA));
		settle();
	endtask

	task automatic test_random_traffic();
		sensor_type_t order [8];
		order = '{ST_LITTLE, ST_BIG_A, ST_BIG_B, ST_NONE,
			ST_LITTLE, ST_BIG_B, ST_BIG_A, ST_LITTLE};
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin src_idle = 0;  snk_stall = 0;  end
				1: begin src_idle = 75; snk_stall = 0;  end
				2: begin src_idle = 0;  snk_stall = 75; end
				default: begin src_idle = 14; snk_stall = 14; end
			endcase
			for (int h = 0; h < 2; h++) begin
				write_sensor(order[2 * p + h]);
				repeat (85) send_beat(random_item(sensor_now));
				settle();
			end
		end
	endtask

	task automatic test_backpressure();
		src_idle = 0;
		snk_stall = 0;
		write_sensor(ST_BIG_A);
		// long receiver hold-off while the sender keeps offering beats
		hold_req++;
		repeat (80) send_beat(random_item(sensor_now));
		// sender waits for every result before going on
		settle();
		write_sensor(ST_LITTLE);
		src_idle = 14;
		snk_stall = 14;
		repeat (20) send_beat(random_item(sensor_now));
		settle();
	endtask

	// receiver: random stalls, plus a counted hold-off on request
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= snk_stall);
		end
	end

	always @(posedge clk) begin
		mgh_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (heading_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$error("output beat with nothing expected: %h", out_data);
			end else begin
				want = heading_due.pop_front();
				if (out_data.heading !== want.heading) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$error("heading: expected %0d, got %0d", want.heading,
							out_data.heading);
				end
				if (out_data.axis_x !== want.axis_x) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$error("axis_x: expected %0d, got %0d", want.axis_x,
							out_data.axis_x);
				end
				if (out_data.axis_y !== want.axis_y) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$error("axis_y: expected %0d, got %0d", want.axis_y,
							out_data.axis_y);
				end
				if (out_data.axis_z !== want.axis_z) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$error("axis_z: expected %0d, got %0d", want.axis_z,
							out_data.axis_z);
				end
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_undefined_type();
		test_special_headings();
		test_random_traffic();
		test_backpressure();
		settle();
		if (mismatches == 0 && heading_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/mgh_pkg.sv
src/mgh_unpack.sv
src/mgh_cordic_stage.sv
src/mgh_finish.sv
src/magnetometer_heading_core.sv
src/mgh_checker.sv
dv/magnetometer_heading_core_tb.sv
